// ===== design/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, command codes and constants for the stereo voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

  // Default sizes
  localparam int unsigned SVM_VOICES       = 8;
  localparam int unsigned SVM_STORE_FRAMES = 65536;

  // Command codes
  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_PLAY   = 3'd1;
  localparam logic [2:0] CMD_LOOP   = 3'd2;
  localparam logic [2:0] CMD_UNLOOP = 3'd3;
  localparam logic [2:0] CMD_HALT   = 3'd4;
  localparam logic [2:0] CMD_MIX    = 3'd5;

  // Limits
  localparam logic [16:0] MAX_LEN    = 17'd65536;
  localparam logic [8:0]  UNITY_GAIN = 9'd256;
  localparam logic signed [17:0] S16_MIN = -18'sd32768;
  localparam logic signed [17:0] S16_MAX = 18'sd32767;

  // One voice table entry
  typedef struct packed {
    logic [15:0] start;
    logic [16:0] length;
    logic [15:0] position;
    logic [8:0]  gain;
  } voice_entry_t;

  localparam int unsigned VOICE_ENTRY_W = $bits(voice_entry_t);

  // Controls from the sequencer to the scale/accumulate datapath
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

endpackage

// ===== design/svm_ram.sv =====
// ----------------------------------------------------------------------------
// svm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module svm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/svm_mac.sv =====
// ----------------------------------------------------------------------------
// svm_mac
// Scale one stereo frame by a voice gain and add it into saturating
// left/right accumulators.
// ----------------------------------------------------------------------------
module svm_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  svm_pkg::mac_ctl_t   ctl,
  input  logic signed [15:0]  sample_left,
  input  logic signed [15:0]  sample_right,
  input  logic [8:0]          gain,
  output logic signed [15:0]  acc_left,
  output logic signed [15:0]  acc_right
);
  import svm_pkg::*;

  logic signed [25:0] prod_l_r, prod_r_r;
  logic signed [15:0] acc_l_r, acc_r_r;
  logic signed [15:0] acc_l_nxt, acc_r_nxt;
  logic signed [9:0]  gain_s;

  // Divide by 256 toward zero: bias negatives by 255, then shift
  function automatic logic signed [17:0] scale_q8(input logic signed [25:0] p);
    logic signed [25:0] biased;
    biased = p + (p[25] ? 26'sd255 : 26'sd0);
    return biased[25:8];
  endfunction

  // Add and clamp to 16 bits
  function automatic logic signed [15:0] add_sat(input logic signed [15:0] acc,
                                                 input logic signed [17:0] term);
    logic signed [17:0] sum;
    sum = 18'(acc) + term;
    if (sum < S16_MIN) begin
      return 16'sh8000;
    end else if (sum > S16_MAX) begin
      return 16'sh7fff;
    end
    return sum[15:0];
  endfunction

  assign gain_s = signed'({1'b0, gain});

  // Register products
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_l_r <= 26'(sample_left) * 26'(gain_s);
      prod_r_r <= 26'(sample_right) * 26'(gain_s);
    end
  end

  always_comb begin
    acc_l_nxt = add_sat(acc_l_r, scale_q8(prod_l_r));
    acc_r_nxt = add_sat(acc_r_r, scale_q8(prod_r_r));
  end

  // Clear at frame start, accumulate once per busy voice
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (ctl.clear) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (ctl.acc_en) begin
      acc_l_r <= acc_l_nxt;
      acc_r_r <= acc_r_nxt;
    end
  end

  assign acc_left  = acc_l_r;
  assign acc_right = acc_r_r;

endmodule

// ===== design/stereo_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// stereo_voice_mixer
// Command-driven mixer of up to VOICES stereo clips held in a sample store.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Word
//  ---------+----------------------+------------------------------------------
//  in_      | in_valid / in_ready  | cmd, frame_addr, clip_length, gain, samples
//  out_     | out_valid / out_ready| mix_left, mix_right (mix_frame only)
//
//  in_ready is high only while the sequencer is idle. Load and halt words
//  complete in the accept cycle; play passes through an allocation state, a
//  loop release scans the voice table (a read and a compare state per voice),
//  and a looped play makes that scan and then allocates.
//  mix_frame reads the voice table for every voice, idle ones included; each
//  busy voice also makes a sample-store read, a multiply and an accumulate.
//  A finished frame waits in the output register; a new word is accepted
//  meanwhile, and a second frame holds in the output state until out_ready.
//  Reset clears voice busy/loop flags; the stores need no clearing.
// ----------------------------------------------------------------------------
module stereo_voice_mixer #(
  parameter int unsigned VOICES       = svm_pkg::SVM_VOICES,
  parameter int unsigned STORE_FRAMES = svm_pkg::SVM_STORE_FRAMES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic [15:0]        in_frame_addr,
  input  logic [16:0]        in_clip_length,
  input  logic [8:0]         in_gain,
  input  logic signed [15:0] in_sample_left,
  input  logic signed [15:0] in_sample_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_mix_left,
  output logic signed [15:0] out_mix_right
);
  import svm_pkg::*;

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned AW = (STORE_FRAMES > 1) ? $clog2(STORE_FRAMES) : 1;
  localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ALLOC  = 4'd1;
  localparam logic [3:0] S_LS_RD  = 4'd2;
  localparam logic [3:0] S_LS_CMP = 4'd3;
  localparam logic [3:0] S_MX_RD  = 4'd4;
  localparam logic [3:0] S_MX_SRD = 4'd5;
  localparam logic [3:0] S_MX_MUL = 4'd6;
  localparam logic [3:0] S_MX_ACC = 4'd7;
  localparam logic [3:0] S_MX_OUT = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [VW-1:0]     vidx_r, vidx_nxt;
  logic [VOICES-1:0] busy_r, busy_nxt;
  logic [VOICES-1:0] loop_r, loop_nxt;

  // Latched command word
  logic [2:0]  cmd_r;
  logic [15:0] addr_r;
  logic [16:0] len_r;
  logic [8:0]  gain_r;
  logic [8:0]  vgain_r;

  logic        out_valid_r, out_valid_nxt;
  logic signed [15:0] out_l_r, out_r_r;

  logic        accept;
  logic [16:0] len_sat;
  logic [8:0]  gain_sat;

  // Memories
  logic                     st_we;
  logic [AW+15:0]           st_waddr_ext;
  logic [AW+16:0]           st_raddr_ext;
  logic [31:0]              st_rdata;
  logic                     vt_we;
  logic [VW-1:0]            vt_waddr;
  voice_entry_t             vt_wdata;
  voice_entry_t             vt_rdata;
  logic [VOICE_ENTRY_W-1:0] vt_rdata_raw;

  logic [VW-1:0] free_idx;
  logic          free_found;
  logic [16:0]   pos_next;
  logic          pos_wrap;
  logic          vbusy;
  logic          last;

  mac_ctl_t          mac_ctl;
  logic signed [15:0] acc_l, acc_r;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign len_sat  = (in_clip_length > MAX_LEN) ? MAX_LEN : in_clip_length;
  assign gain_sat = (in_gain > UNITY_GAIN) ? UNITY_GAIN : in_gain;
  assign vbusy    = busy_r[vidx_r];
  assign last     = (vidx_r == LAST_VOICE);

  // Sample store: written on load_sample, read during mixing
  assign st_we        = accept && (in_cmd == CMD_LOAD);
  assign st_waddr_ext = (AW + 16)'(in_frame_addr);
  assign st_raddr_ext = (AW + 17)'(vt_rdata.start) + (AW + 17)'(vt_rdata.position);

  svm_ram #(
    .WIDTH (32),
    .DEPTH (STORE_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr_ext[AW-1:0]),
    .wdata ({in_sample_right, in_sample_left}),
    .raddr (st_raddr_ext[AW-1:0]),
    .rdata (st_rdata)
  );

  // Voice table
  svm_ram #(
    .WIDTH (VOICE_ENTRY_W),
    .DEPTH (VOICES)
  ) u_voices (
    .clk   (clk),
    .we    (vt_we),
    .waddr (vt_waddr),
    .wdata (vt_wdata),
    .raddr (vidx_r),
    .rdata (vt_rdata_raw)
  );

  assign vt_rdata = voice_entry_t'(vt_rdata_raw);

  // Find the lowest free voice
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_idx   = VW'(i);
        free_found = 1'b1;
      end
    end
  end

  // Position advance for the voice being mixed
  assign pos_next = {1'b0, vt_rdata.position} + 17'd1;
  assign pos_wrap = (pos_next >= vt_rdata.length);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    vidx_nxt      = vidx_r;
    busy_nxt      = busy_r;
    loop_nxt      = loop_r;
    out_valid_nxt = out_valid_r;
    vt_we         = 1'b0;
    vt_waddr      = vidx_r;
    vt_wdata      = vt_rdata;
    mac_ctl       = '0;

    // Drop the output word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          vidx_nxt = '0;
          case (in_cmd)
            CMD_PLAY:   state_nxt = S_ALLOC;
            CMD_LOOP:   state_nxt = S_LS_RD;
            CMD_UNLOOP: state_nxt = S_LS_RD;
            CMD_HALT:   busy_nxt  = '0;
            CMD_MIX: begin
              mac_ctl.clear = 1'b1;
              state_nxt     = S_MX_RD;
            end
            default: ;
          endcase
        end
      end

      // Take the lowest free voice
      S_ALLOC: begin
        if ((len_r != '0) && free_found) begin
          vt_we             = 1'b1;
          vt_waddr          = free_idx;
          vt_wdata.start    = addr_r;
          vt_wdata.length   = len_r;
          vt_wdata.position = '0;
          vt_wdata.gain     = gain_r;
          busy_nxt[free_idx] = 1'b1;
          loop_nxt[free_idx] = (cmd_r == CMD_LOOP);
        end
        state_nxt = S_IDLE;
      end

      S_LS_RD: begin
        state_nxt = S_LS_CMP;
      end

      // Free looping voices on the same clip
      S_LS_CMP: begin
        if (vbusy && loop_r[vidx_r] && (vt_rdata.start == addr_r)) begin
          busy_nxt[vidx_r] = 1'b0;
        end
        if (last) begin
          state_nxt = (cmd_r == CMD_LOOP) ? S_ALLOC : S_IDLE;
        end else begin
          vidx_nxt  = vidx_r + 1'b1;
          state_nxt = S_LS_RD;
        end
      end

      // Skip idle voices
      S_MX_RD: begin
        if (vbusy) begin
          state_nxt = S_MX_SRD;
        end else if (last) begin
          state_nxt = S_MX_OUT;
        end else begin
          vidx_nxt = vidx_r + 1'b1;
        end
      end

      // Issue the store read, write back the advanced position
      S_MX_SRD: begin
        vt_we = 1'b1;
        if (pos_wrap) begin
          vt_wdata.position = '0;
          if (!loop_r[vidx_r]) begin
            busy_nxt[vidx_r] = 1'b0;
          end
        end else begin
          vt_wdata.position = pos_next[15:0];
        end
        state_nxt = S_MX_MUL;
      end

      S_MX_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_nxt      = S_MX_ACC;
      end

      S_MX_ACC: begin
        mac_ctl.acc_en = 1'b1;
        if (last) begin
          state_nxt = S_MX_OUT;
        end else begin
          vidx_nxt  = vidx_r + 1'b1;
          state_nxt = S_MX_RD;
        end
      end

      // Hold until the output register is free
      S_MX_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vidx_r      <= '0;
      busy_r      <= '0;
      loop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vidx_r      <= vidx_nxt;
      busy_r      <= busy_nxt;
      loop_r      <= loop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      addr_r <= in_frame_addr;
      len_r  <= len_sat;
      gain_r <= gain_sat;
    end
    if (state_r == S_MX_SRD) begin
      vgain_r <= vt_rdata.gain;
    end
    if ((state_r == S_MX_OUT) && (!out_valid_r || out_ready)) begin
      out_l_r <= acc_l;
      out_r_r <= acc_r;
    end
  end

  svm_mac u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (mac_ctl),
    .sample_left  (signed'(st_rdata[15:0])),
    .sample_right (signed'(st_rdata[31:16])),
    .gain         (vgain_r),
    .acc_left     (acc_l),
    .acc_right    (acc_r)
  );

  assign out_valid     = out_valid_r;
  assign out_mix_left  = out_l_r;
  assign out_mix_right = out_r_r;

endmodule

// ===== bench/svm_checker.sv =====
// ----------------------------------------------------------------------------
// svm_checker
// Watches both channels of the stereo voice mixer. It keeps its own sample
// store and voice table and works out the mixed frame for every mix_frame
// word it sees accepted. Each frame that leaves the mixer is compared, field
// by field, with the oldest frame still due.
// ----------------------------------------------------------------------------
module svm_checker #(
  parameter int unsigned VOICES       = svm_pkg::SVM_VOICES,
  parameter int unsigned STORE_FRAMES = svm_pkg::SVM_STORE_FRAMES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic [15:0]        in_frame_addr,
  input  logic [16:0]        in_clip_length,
  input  logic [8:0]         in_gain,
  input  logic signed [15:0] in_sample_left,
  input  logic signed [15:0] in_sample_right,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_mix_left,
  input  logic signed [15:0] out_mix_right,
  output int                 frames_due,
  output int                 mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import svm_pkg::*;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } frame_t;

  // Shadow state: right sample in the high half of a store entry
  logic [31:0]  store_mem [STORE_FRAMES];
  voice_entry_t voice [VOICES];
  logic         voice_busy [VOICES];
  logic         voice_looping [VOICES];

  frame_t frame_q [$];
  int     errs = 0;

  function automatic void note(string msg);
    if (errs < 10) $display("%s", msg);
    errs++;
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    if (v < S16_MIN) return 16'sh8000;
    if (v > S16_MAX) return 16'sh7fff;
    return v[15:0];
  endfunction

  // Integer division truncates toward zero, as the mixer must
  function automatic int scaled(logic signed [15:0] smp, logic [8:0] g);
    return (int'(smp) * int'(g)) / 256;
  endfunction

  function automatic void drop_loops(logic [15:0] start);
    for (int v = 0; v < VOICES; v++)
      if (voice_busy[v] && voice_looping[v] && voice[v].start == start)
        voice_busy[v] = 1'b0;
  endfunction

  // Take the lowest free voice; drop the word if none is free or the length is zero
  function automatic void grab_voice(logic [15:0] start, logic [16:0] len,
                                     logic [8:0] g, logic looping);
    logic [16:0] l;
    logic [8:0]  gg;
    l  = (len > MAX_LEN) ? MAX_LEN : len;
    gg = (g > UNITY_GAIN) ? UNITY_GAIN : g;
    if (l == '0) return;
    for (int v = 0; v < VOICES; v++) begin
      if (!voice_busy[v]) begin
        voice_busy[v]     = 1'b1;
        voice_looping[v]  = looping;
        voice[v].start    = start;
        voice[v].length   = l;
        voice[v].position = '0;
        voice[v].gain     = gg;
        return;
      end
    end
  endfunction

  // Sum busy voices in ascending order, saturating after each add, then advance
  function automatic frame_t mix_voices();
    int          acc_l;
    int          acc_r;
    logic [31:0] w;
    frame_t      f;
    acc_l = 0;
    acc_r = 0;
    for (int v = 0; v < VOICES; v++) begin
      if (voice_busy[v]) begin
        w = store_mem[(int'(voice[v].start) + int'(voice[v].position)) % STORE_FRAMES];
        acc_l = sat16(acc_l + scaled(w[15:0], voice[v].gain));
        acc_r = sat16(acc_r + scaled(w[31:16], voice[v].gain));
        if (int'(voice[v].position) + 1 >= int'(voice[v].length)) begin
          voice[v].position = '0;
          if (!voice_looping[v]) voice_busy[v] = 1'b0;
        end else begin
          voice[v].position = voice[v].position + 16'd1;
        end
      end
    end
    f.left  = acc_l[15:0];
    f.right = acc_r[15:0];
    return f;
  endfunction

  always @(posedge clk) begin : watch
    frame_t got;
    frame_t want;
    frame_t fresh;
    if (!rst_n) begin
      // clear the voice table; the store stays as it is
      for (int v = 0; v < VOICES; v++) begin
        voice_busy[v]    = 1'b0;
        voice_looping[v] = 1'b0;
        voice[v]         = '0;
      end
      frame_q.delete();
    end else begin
      // compare a finished frame with the oldest one due
      if (out_valid && out_ready) begin
        got.left  = out_mix_left;
        got.right = out_mix_right;
        if (frame_q.size() == 0) begin
          note($sformatf("unexpected mix frame: left %0d right %0d", got.left, got.right));
        end else begin
          want = frame_q.pop_front();
          if (got.left !== want.left)
            note($sformatf("mix_left mismatch: expected %0d, got %0d", want.left, got.left));
          if (got.right !== want.right)
            note($sformatf("mix_right mismatch: expected %0d, got %0d", want.right,
                           got.right));
        end
      end
      // apply an accepted command word to the shadow state
      if (in_valid && in_ready) begin
        case (in_cmd)
          CMD_LOAD:
            store_mem[in_frame_addr % STORE_FRAMES] = {in_sample_right, in_sample_left};
          CMD_PLAY:
            grab_voice(in_frame_addr, in_clip_length, in_gain, 1'b0);
          CMD_LOOP: begin
            drop_loops(in_frame_addr);
            grab_voice(in_frame_addr, in_clip_length, in_gain, 1'b1);
          end
          CMD_UNLOOP:
            drop_loops(in_frame_addr);
          CMD_HALT:
            for (int v = 0; v < VOICES; v++) voice_busy[v] = 1'b0;
          CMD_MIX: begin
            // queue the predicted frame at the tail
            fresh   = mix_voices();
            frame_q = {frame_q, fresh};
          end
          default: ;
        endcase
      end
    end
    frames_due <= frame_q.size();
    mismatches <= errs;
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives command words into the stereo voice mixer: a short directed run over
// the edge cases, then random sessions that load clips, play and loop them,
// mix a bounded number of frames and stop all voices. Both channels idle at
// random; the checker beside the mixer predicts and compares the frames.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import svm_pkg::*;

  // Command codes the mixer ignores
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int WORDS_WANTED = 1250;
  localparam int MAX_CLIPS    = 3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_cmd;
  logic [15:0]        in_frame_addr;
  logic [16:0]        in_clip_length;
  logic [8:0]         in_gain;
  logic signed [15:0] in_sample_left;
  logic signed [15:0] in_sample_right;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_mix_left;
  logic signed [15:0] out_mix_right;
  int                 frames_due;
  int                 mismatches;
  int                 words_sent;
  bit                 sender_calm;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  stereo_voice_mixer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_frame_addr   (in_frame_addr),
    .in_clip_length  (in_clip_length),
    .in_gain         (in_gain),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mix_left    (out_mix_left),
    .out_mix_right   (out_mix_right)
  );

  svm_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_frame_addr   (in_frame_addr),
    .in_clip_length  (in_clip_length),
    .in_gain         (in_gain),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mix_left    (out_mix_left),
    .out_mix_right   (out_mix_right),
    .frames_due      (frames_due),
    .mismatches      (mismatches)
  );

  // Offer one word, maybe after a random gap, and hold it until accepted
  task automatic send_word(input logic [2:0] cmd, input logic [15:0] addr,
                           input logic [16:0] len, input logic [8:0] gain,
                           input logic [15:0] left, input logic [15:0] right);
    if (!sender_calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_frame_addr   <= addr;
    in_clip_length  <= len;
    in_gain         <= gain;
    in_sample_left  <= left;
    in_sample_right <= right;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] pick_gain();
    case ($urandom_range(7))
      0:       return UNITY_GAIN;
      1:       return 9'd0;
      2:       return 9'h1ff;
      3:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(0, 256));
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off, one stretch always ready
  initial begin : receiver
    int cycle;
    out_ready = 1'b0;
    cycle     = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (cycle >= 1500 && cycle < 1900) out_ready <= 1'b0;
      else if (cycle >= 4000 && cycle < 7000) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 33);
      cycle++;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [15:0] clip_start [MAX_CLIPS];
    int          clip_room [MAX_CLIPS];
    int          frames_planned;
    int          mixes_left;
    int          n_clips;
    int          k;
    int          pick;
    int          session;
    logic [16:0] len;

    in_valid        = 1'b0;
    in_cmd          = CMD_LOAD;
    in_frame_addr   = '0;
    in_clip_length  = '0;
    in_gain         = '0;
    in_sample_left  = '0;
    in_sample_right = '0;
    rst_n           = 1'b0;
    words_sent      = 0;
    sender_calm     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // silence, then ignored codes
    send_word(CMD_MIX, '0, '0, '0, '0, '0);
    send_word(CMD_SPARE_A, 16'hffff, 17'h1ffff, 9'h1ff, 16'hffff, 16'hffff);
    send_word(CMD_SPARE_B, 16'h0000, 17'h00000, 9'h000, 16'h0000, 16'h0000);
    // extreme frames around the store wrap
    send_word(CMD_LOAD, 16'hffff, '0, '0, 16'h7fff, 16'h8000);
    send_word(CMD_LOAD, 16'h0000, '0, '0, 16'h8000, 16'h7fff);
    send_word(CMD_LOAD, 16'h0001, '0, '0, 16'hffff, 16'h0001);
    send_word(CMD_LOAD, 16'h0002, '0, '0, 16'h7fff, 16'h7fff);
    // zero length is dropped; then one-shot, loop, oversized length and gain
    send_word(CMD_PLAY, 16'hffff, 17'd0, UNITY_GAIN, '0, '0);
    send_word(CMD_PLAY, 16'hffff, 17'd3, UNITY_GAIN, '0, '0);
    send_word(CMD_LOOP, 16'hffff, 17'd2, 9'h1ff, '0, '0);
    send_word(CMD_PLAY, 16'hffff, 17'h1ffff, 9'd128, '0, '0);
    send_word(CMD_LOOP, 16'h0000, 17'd1, 9'd1, '0, '0);
    // fill the remaining voices; the last play finds none free
    repeat (5) send_word(CMD_PLAY, 16'h0002, 17'd1, UNITY_GAIN, '0, '0);
    send_word(CMD_MIX, '0, '0, '0, '0, '0);
    // restart a looping clip, which frees its old voice first
    send_word(CMD_LOOP, 16'hffff, 17'd4, 9'd0, '0, '0);
    send_word(CMD_MIX, '0, '0, '0, '0, '0);
    send_word(CMD_UNLOOP, 16'h1234, '0, '0, '0, '0);
    send_word(CMD_UNLOOP, 16'h0000, '0, '0, '0, '0);
    send_word(CMD_MIX, '0, '0, '0, '0, '0);
    send_word(CMD_PLAY, 16'h0000, MAX_LEN, 9'd300, '0, '0);
    send_word(CMD_MIX, '0, '0, '0, '0, '0);
    send_word(CMD_HALT, '0, '0, '0, '0, '0);
    send_word(CMD_MIX, '0, '0, '0, '0, '0);

    // Random sessions. A session mixes at most frames_planned frames, so a
    // voice never reads past the frames loaded for its clip; a halt ends it.
    session = 0;
    while (words_sent < WORDS_WANTED) begin
      sender_calm    = (session >= 6 && session < 10);
      frames_planned = $urandom_range(2, 16);
      mixes_left     = frames_planned;
      n_clips        = $urandom_range(1, MAX_CLIPS);

      // load each clip, some of them across the top of the store
      for (k = 0; k < n_clips; k++) begin
        clip_start[k] = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hfff0, 16'hffff))
                                                 : 16'($urandom);
        clip_room[k]  = ($urandom_range(2) == 0) ? frames_planned
                                                 : $urandom_range(1, frames_planned);
        for (int j = 0; j < clip_room[k]; j++)
          send_word(CMD_LOAD, clip_start[k] + 16'(j), 17'($urandom), 9'($urandom),
                    pick_sample(), pick_sample());
      end

      while (mixes_left > 0) begin
        k    = $urandom_range(n_clips - 1);
        pick = $urandom_range(99);
        if (pick < 35) begin
          send_word(CMD_MIX, 16'($urandom), 17'($urandom), 9'($urandom),
                    16'($urandom), 16'($urandom));
          mixes_left--;
        end else if (pick < 75) begin
          // long lengths only on clips loaded for the whole session
          if (clip_room[k] == frames_planned && $urandom_range(2) == 0) begin
            case ($urandom_range(2))
              0:       len = MAX_LEN;
              1:       len = 17'h1ffff;
              default: len = 17'($urandom_range(1, 131071));
            endcase
          end else begin
            len = 17'($urandom_range(1, clip_room[k]));
          end
          send_word((pick < 60) ? CMD_PLAY : CMD_LOOP, clip_start[k], len,
                    pick_gain(), 16'($urandom), 16'($urandom));
        end else if (pick < 83) begin
          send_word(CMD_UNLOOP,
                    ($urandom_range(3) == 0) ? 16'($urandom) : clip_start[k],
                    17'($urandom), 9'($urandom), 16'($urandom), 16'($urandom));
        end else if (pick < 89) begin
          send_word(CMD_LOAD, 16'($urandom), 17'($urandom), 9'($urandom),
                    pick_sample(), pick_sample());
        end else if (pick < 92) begin
          send_word(CMD_HALT, 16'($urandom), 17'($urandom), 9'($urandom),
                    16'($urandom), 16'($urandom));
        end else if (pick < 96) begin
          // zero length: dropped whatever the start
          send_word(($urandom_range(1) == 0) ? CMD_PLAY : CMD_LOOP, 16'($urandom),
                    17'd0, 9'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          send_word(($urandom_range(1) == 0) ? CMD_SPARE_A : CMD_SPARE_B, 16'($urandom),
                    17'($urandom), 9'($urandom), 16'($urandom), 16'($urandom));
        end
      end

      send_word(CMD_HALT, 16'($urandom), 17'($urandom), 9'($urandom),
                16'($urandom), 16'($urandom));
      session++;
    end

    // drain: wait for every frame due, then let the last command settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
